// ===== hdl/ftt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ftt_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;
   localparam int ENTRY_INDEX_W = 6;
   localparam int STATUS_W = 2;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } key_type;

   typedef struct packed {
      logic                     valid;
      logic                     hit;
      logic [ENTRY_INDEX_W-1:0] index;
      key_type                  key;
   } probe_type;

endpackage

`default_nettype wire

// ===== hdl/ftt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftt_cell
   import ftt_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int CELL_ID = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             wr_en,
   input  wire key_type          wr_key,
   input  wire probe_type        probe_in,
   output probe_type             probe_out
);

   key_type   key_ff;
   probe_type probe_ff;
   probe_type probe_in_next;
   logic      occupied;
   logic      match;

   assign occupied = count > CNT_W'(CELL_ID);
   assign match    = occupied && (key_ff == probe_in.key);

   always_comb begin
      probe_in_next = probe_in;
      if (!probe_in.hit && match) begin
         probe_in_next.hit   = 1'b1;
         probe_in_next.index = ENTRY_INDEX_W'(CELL_ID);
      end
   end

   // key slot, written only when this cell is the next free one
   always_ff @(posedge clock) begin
      if (wr_en && (count == CNT_W'(CELL_ID))) begin
         key_ff <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_next.valid;
      end
      probe_ff.hit   <= probe_in_next.hit;
      probe_ff.index <= probe_in_next.index;
      probe_ff.key   <= probe_in_next.key;
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

// ===== hdl/flow_tuple_table_core.sv =====
// Exact-match table of connection keys, built as a row of TABLE_ENTRIES key cells. An add
// writes the key into the next free cell, and the result strobes on the
// cycle after start, so adds can be issued back to back. A search word enters the first cell
// and moves one cell per cycle, each cell checking it against its stored key and keeping the
// lowest hit; busy is set on start and cleared as the word leaves the last cell, and the
// result is then registered. The length of the cell row sets how long a search lasts.
// Each result is shown for exactly one cycle on rsp_strobe and the receiver cannot stall it.
// The table is emptied only by reset, which clears the entry count.
`timescale 1ns / 1ps
`default_nettype none

module flow_tuple_table_core
   import ftt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_cmd,
   input  wire logic [31:0]              req_src_addr,
   input  wire logic [31:0]              req_dst_addr,
   input  wire logic [15:0]              req_src_port,
   input  wire logic [15:0]              req_dst_port,
   output logic                          rsp_strobe,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [ENTRY_INDEX_W-1:0]      rsp_entry_index
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ENTRY_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic      accept;
   logic      full;
   logic      do_add;
   logic      do_search;
   key_type   req_key;
   probe_type link [0:TABLE_ENTRIES];

   assign accept    = start && !busy_ff;
   assign full      = count_ff == CNT_W'(TABLE_ENTRIES);
   assign do_add    = accept && (req_cmd == CMD_ADD) && !full;
   assign do_search = accept && (req_cmd == CMD_SEARCH);

   assign req_key.src_addr = req_src_addr;
   assign req_key.dst_addr = req_dst_addr;
   assign req_key.src_port = req_src_port;
   assign req_key.dst_port = req_dst_port;

   always_comb begin
      link[0].valid = do_search;
      link[0].hit   = 1'b0;
      link[0].index = '0;
      link[0].key   = req_key;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ftt_cell #(
         .CNT_W   (CNT_W),
         .CELL_ID (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .wr_en     (do_add),
         .wr_key    (req_key),
         .probe_in  (link[i]),
         .probe_out (link[i+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      if (accept && (req_cmd == CMD_ADD)) begin
         rsp_strobe_in = 1'b1;
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_index_in = ENTRY_INDEX_W'(count_ff);
            count_in     = count_ff + CNT_W'(1);
         end
      end else if (do_search) begin
         busy_in = 1'b1;
      end else if (link[TABLE_ENTRIES].valid) begin
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b1;
         if (link[TABLE_ENTRIES].hit) begin
            rsp_index_in = link[TABLE_ENTRIES].index;
         end else begin
            rsp_status_in = ST_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign busy            = busy_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count above capacity");

   a_add_result : assert property (@(posedge clock) disable iff (reset)
      do_add |=> rsp_strobe && (rsp_status == ST_OK) && (count_ff == $past(count_ff) + 1'b1))
      else $error("add did not return ok or advance count");

   a_search_busy : assert property (@(posedge clock) disable iff (reset)
      do_search |=> busy && !rsp_strobe)
      else $error("search did not hold busy");

   a_chain_end : assert property (@(posedge clock) disable iff (reset)
      link[TABLE_ENTRIES].valid |-> busy_ff)
      else $error("search word left chain while idle");

   a_index_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> rsp_entry_index == '0)
      else $error("nonzero index on failed result");

endmodule

`default_nettype wire
